@@ hw/rtl/rpc_pkg.sv @@
// Shared types, constants and bucket mask functions of the detector pattern rate counter.
package rpc_pkg;

    localparam int COUNT_WIDTH = 32;
    localparam int MAX_BUCKETS = 10;
    localparam int TIME_WIDTH  = 64;
    localparam int WLEN_WIDTH  = 48;
    localparam int CFG_IDX_W   = 4;
    localparam int FINE_SHIFT  = 15;

    localparam logic [5:0] PAT_MASK      = 6'h3f;
    localparam logic [5:0] MARKER_DUMMY  = 6'h30;
    localparam logic [5:0] MARKER_BIT    = 6'h20;
    localparam logic [5:0] DUMMY_BIT     = 6'h10;
    localparam logic [5:0] LINE_BITS     = 6'h0f;
    localparam logic [5:0] PAIR12_TEST   = 6'h13;
    localparam logic [5:0] PAIR23_TEST   = 6'h16;
    localparam logic [5:0] PAIR34_TEST   = 6'h1c;
    localparam logic [5:0] PAIR41_TEST   = 6'h19;
    localparam logic [5:0] PAIR_STRICT   = 6'h1f;
    localparam logic [5:0] PAIR12        = 6'h03;
    localparam logic [5:0] PAIR23        = 6'h06;
    localparam logic [5:0] PAIR34        = 6'h0c;
    localparam logic [5:0] PAIR41        = 6'h09;
    localparam logic [5:0] NO_MATCH      = 6'h3f;

    typedef logic [3:0]                                   bucket_idx_t;
    typedef logic [COUNT_WIDTH-1:0]                       count_t;
    typedef logic [MAX_BUCKETS-1:0][COUNT_WIDTH-1:0]      count_vec_t;
    typedef logic [TIME_WIDTH-1:0]                        time_t;

    typedef enum logic [1:0] {
        MODE_TOTAL = 2'd0,
        MODE_FOUR  = 2'd1,
        MODE_SIX   = 2'd2,
        MODE_EIGHT = 2'd3
    } split_mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SPLIT_MODE  = 4'd0,
        REG_COINCIDENCE = 4'd1,
        REG_MARKER      = 4'd2,
        REG_WINDOW      = 4'd3
    } reg_idx_t;

    typedef struct packed {
        split_mode_t             split_mode;
        logic                    coincidence_correct;
        logic                    marker_split;
        logic [WLEN_WIDTH-1:0]   window_length;
    } cfg_t;

    typedef struct packed {
        logic         load;
        bucket_idx_t  num;
        count_vec_t   counts;
    } snap_t;

    function automatic bucket_idx_t bucket_num(input cfg_t cfg);
        bucket_idx_t n;
        n = '0;
        if (cfg.marker_split) begin
            unique case (cfg.split_mode)
                MODE_TOTAL: n = 4'd2;
                MODE_FOUR:  n = 4'd10;
                MODE_SIX,
                MODE_EIGHT: n = 4'd0;
                default:    n = 4'd0;
            endcase
        end
        else begin
            unique case (cfg.split_mode)
                MODE_TOTAL: n = 4'd1;
                MODE_FOUR:  n = 4'd5;
                MODE_SIX:   n = 4'd7;
                MODE_EIGHT: n = 4'd9;
                default:    n = 4'd1;
            endcase
        end
        return n;
    endfunction

    // Per-bucket hit: (pattern & test) == result; inactive buckets never hit.
    function automatic logic [MAX_BUCKETS-1:0] bucket_hits(input logic [5:0] pat,
                                                           input cfg_t cfg);
        logic [5:0] tm [MAX_BUCKETS];
        logic [5:0] rm [MAX_BUCKETS];
        logic [5:0] dp;
        logic [5:0] dm;
        logic [MAX_BUCKETS-1:0] hit;
        for (int k = 0; k < MAX_BUCKETS; k++) begin
            tm[k] = '0;
            rm[k] = NO_MATCH;
        end
        if (cfg.marker_split) begin
            if (cfg.split_mode == MODE_TOTAL || cfg.split_mode == MODE_FOUR) begin
                tm[0] = MARKER_DUMMY; rm[0] = '0;
                tm[1] = MARKER_DUMMY; rm[1] = MARKER_BIT;
                if (cfg.split_mode == MODE_FOUR) begin
                    for (int j = 0; j < 4; j++) begin
                        dp = '0;
                        dp[j] = 1'b1;
                        dm = cfg.coincidence_correct ? dp : LINE_BITS;
                        tm[2 + j] = MARKER_DUMMY | dm; rm[2 + j] = dp;
                        tm[6 + j] = MARKER_DUMMY | dm; rm[6 + j] = MARKER_BIT | dp;
                    end
                end
            end
        end
        else begin
            tm[0] = DUMMY_BIT; rm[0] = '0;
            if (cfg.split_mode != MODE_TOTAL) begin
                for (int j = 0; j < 4; j++) begin
                    dp = '0;
                    dp[j] = 1'b1;
                    dm = cfg.coincidence_correct ? dp : LINE_BITS;
                    tm[1 + j] = DUMMY_BIT | dm; rm[1 + j] = dp;
                end
            end
            if (cfg.split_mode == MODE_SIX || cfg.split_mode == MODE_EIGHT) begin
                tm[5] = cfg.coincidence_correct ? PAIR12_TEST : PAIR_STRICT; rm[5] = PAIR12;
                tm[6] = cfg.coincidence_correct ? PAIR23_TEST : PAIR_STRICT; rm[6] = PAIR23;
            end
            if (cfg.split_mode == MODE_EIGHT) begin
                tm[7] = cfg.coincidence_correct ? PAIR34_TEST : PAIR_STRICT; rm[7] = PAIR34;
                tm[8] = cfg.coincidence_correct ? PAIR41_TEST : PAIR_STRICT; rm[8] = PAIR41;
            end
        end
        for (int k = 0; k < MAX_BUCKETS; k++) begin
            hit[k] = ((pat & PAT_MASK & tm[k]) == rm[k]);
        end
        return hit;
    endfunction

endpackage

@@ hw/rtl/rpc_event_if.sv @@
// Event input channel: one timestamped detector event per beat.
interface rpc_event_if
    import rpc_pkg::*;
();
    logic        valid;
    logic        ready;
    logic [31:0] coarse_word;
    logic [31:0] fine_word;

    modport source (output valid, output coarse_word, output fine_word, input ready);
    modport sink   (input valid, input coarse_word, input fine_word, output ready);
endinterface

@@ hw/rtl/rpc_bucket_if.sv @@
// Report output channel: one bucket count per beat.
interface rpc_bucket_if
    import rpc_pkg::*;
();
    logic        valid;
    logic        ready;
    bucket_idx_t bucket_index;
    logic [31:0] bucket_total;
    logic        last_bucket;

    modport source (output valid, output bucket_index, output bucket_total,
                    output last_bucket, input ready);
    modport sink   (input valid, input bucket_index, input bucket_total,
                    input last_bucket, output ready);
endinterface

@@ hw/rtl/rpc_cfg_if.sv @@
// Configuration write channel: register index and write data per beat.
interface rpc_cfg_if
    import rpc_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [WLEN_WIDTH-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/rpc_cfg_regs.sv @@
// Configuration register file of the rate counter.
module rpc_cfg_regs
    import rpc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    rpc_cfg_if.sink   cfg,
    output cfg_t      cfg_out
);
    cfg_t cfg_reg;

    assign cfg.ready = 1'b1;
    assign cfg_out   = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.split_mode          <= MODE_TOTAL;
            cfg_reg.coincidence_correct <= 1'b0;
            cfg_reg.marker_split        <= 1'b0;
            cfg_reg.window_length       <= WLEN_WIDTH'(64'h1_0000_0000);
        end
        else if (cfg.valid)
        begin
            unique case (reg_idx_t'(cfg.index))
                REG_SPLIT_MODE:  cfg_reg.split_mode          <= split_mode_t'(cfg.data[1:0]);
                REG_COINCIDENCE: cfg_reg.coincidence_correct <= cfg.data[0];
                REG_MARKER:      cfg_reg.marker_split        <= cfg.data[0];
                REG_WINDOW:      cfg_reg.window_length       <= cfg.data;
                default:         ;
            endcase
        end
    end
endmodule

@@ hw/rtl/rpc_counter.sv @@
// Input register, window tracking and saturating bucket counters.
module rpc_counter
    import rpc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    rpc_event_if.sink events,
    input  logic      report_busy,
    output snap_t     snap
);
    logic        in_valid_reg;
    logic [31:0] coarse_reg;
    logic [31:0] fine_reg;
    logic        started_reg;
    time_t       window_end_reg;
    count_vec_t  counts_reg;
    count_vec_t  counts_next;

    time_t                  evt_time;
    time_t                  wlen;
    logic                   passed;
    logic                   consume;
    logic [MAX_BUCKETS-1:0] hits;
    bucket_idx_t            num;
    count_t                 base;

    assign evt_time = TIME_WIDTH'({coarse_reg, fine_reg[31:FINE_SHIFT]});
    assign wlen     = TIME_WIDTH'(cfg.window_length);
    assign passed   = started_reg && (evt_time > window_end_reg);
    // Hold a window-closing event while the previous report still drains.
    assign consume  = in_valid_reg && !(passed && report_busy);
    assign events.ready = !in_valid_reg || consume;
    assign hits     = bucket_hits(fine_reg[5:0], cfg);
    assign num      = bucket_num(cfg);

    always_comb
    begin
        counts_next = counts_reg;
        for (int k = 0; k < MAX_BUCKETS; k++)
        begin
            base = passed ? '0 : counts_reg[k];
            counts_next[k] = base + COUNT_WIDTH'(hits[k] && (base != '1));
        end
    end

    assign snap.load   = consume && passed && (num != '0);
    assign snap.num    = num;
    assign snap.counts = counts_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            started_reg    <= 1'b0;
            window_end_reg <= '0;
            counts_reg     <= '0;
        end
        else
        begin
            if (events.ready)
            begin
                in_valid_reg <= events.valid;
            end
            if (consume)
            begin
                if (!started_reg)
                begin
                    // First event only arms the window.
                    started_reg    <= 1'b1;
                    window_end_reg <= evt_time + wlen;
                end
                else
                begin
                    if (passed)
                    begin
                        window_end_reg <= window_end_reg + wlen;
                    end
                    counts_reg <= counts_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (events.valid && events.ready)
        begin
            coarse_reg <= events.coarse_word;
            fine_reg   <= events.fine_word;
        end
    end
endmodule

@@ hw/rtl/rpc_report.sv @@
// Report buffer: holds the closed window's counts and streams one bucket per beat.
module rpc_report
    import rpc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  snap_t         snap,
    output logic          busy,
    rpc_bucket_if.source  buckets
);
    logic        busy_reg;
    bucket_idx_t idx_reg;
    bucket_idx_t num_reg;
    count_vec_t  snap_reg;
    logic        last;

    assign last                 = (idx_reg == num_reg - 4'd1);
    assign busy                 = busy_reg;
    assign buckets.valid        = busy_reg;
    assign buckets.bucket_index = idx_reg;
    assign buckets.bucket_total = 32'(snap_reg[idx_reg]);
    assign buckets.last_bucket  = last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
            num_reg  <= '0;
        end
        else if (snap.load)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
            num_reg  <= snap.num;
        end
        else if (buckets.valid && buckets.ready)
        begin
            if (last)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (snap.load)
        begin
            snap_reg <= snap.counts;
        end
    end
endmodule

@@ hw/rtl/detector_pattern_rate_counter_top.sv @@
// Top level of the detector pattern rate counter.
// Takes one detector event per cycle, except while a window-closing event is held; its
// time is {coarse_word, fine_word[31:15]} and its pattern fine_word[5:0]. The first event
// after reset arms the window end and is not counted. An event past the window end closes
// the window: the active bucket counts go out on the buckets channel, one bucket per beat
// in index order with last_bucket on the final one, the counts clear and the event is
// counted into the new window. An event is held in the input register, from which the
// counter stage updates all buckets at once. A report carries one beat per active bucket
// (up to ten); it is held in its own buffer, so events keep flowing while it drains, and
// only a second window-closing event waits until the last beat of the previous report is
// taken. Configuration writes take effect on the next event and do not clear the counts.
module detector_pattern_rate_counter_top
    import rpc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    rpc_event_if.sink    events,
    rpc_bucket_if.source buckets,
    rpc_cfg_if.sink      cfg
);
    cfg_t  cfg_cur;
    snap_t snap;
    logic  report_busy;

    rpc_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_out (cfg_cur)
    );

    rpc_counter u_counter (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_cur),
        .events      (events),
        .report_busy (report_busy),
        .snap        (snap)
    );

    rpc_report u_report (
        .clk     (clk),
        .rst_n   (rst_n),
        .snap    (snap),
        .busy    (report_busy),
        .buckets (buckets)
    );
endmodule

@@ hw/rtl/rpc_checker.sv @@
// Port-level checker for the rate counter report stream, bound to the top level.
module rpc_checker
    import rpc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input bucket_idx_t out_index,
    input logic [31:0] out_total,
    input logic        out_last
);
    logic out_fire;

    assign out_fire = out_valid && out_ready;

    // A stalled beat keeps its payload.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_index)
            && $stable(out_total) && $stable(out_last))
        else $error("report beat changed while stalled");

    // Buckets within a report come in consecutive order.
    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && !out_last |=> out_valid && (out_index == $past(out_index) + 4'd1))
        else $error("bucket index did not advance by one");

    // A report ends after its last beat is taken.
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && out_last |=> !out_valid)
        else $error("report continued after last bucket");

    // Every report starts at bucket zero.
    a_first_zero: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> out_index == '0)
        else $error("report did not start at bucket zero");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_index <= 4'(MAX_BUCKETS - 1))
        else $error("bucket index out of range");
endmodule

bind detector_pattern_rate_counter_top rpc_checker u_rpc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (buckets.valid),
    .out_ready (buckets.ready),
    .out_index (buckets.bucket_index),
    .out_total (buckets.bucket_total),
    .out_last  (buckets.last_bucket)
);
